FILE: design/dep_pkg.sv
package dep_pkg;

    typedef enum logic [1:0] {
        ST_DATA = 2'd0,
        ST_END  = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    localparam logic [15:0] HDR_BYTES   = 16'd8;
    localparam logic [15:0] POS_RL_LO   = 16'd4;
    localparam logic [15:0] POS_RL_HI   = 16'd5;
    localparam logic [15:0] POS_NAMELEN = 16'd6;
    localparam logic [15:0] POS_KIND    = 16'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       dir_start;
        logic       dir_end;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] entry_inode;
        logic [15:0] record_length;
        logic [7:0]  name_length;
        logic [7:0]  file_kind;
        logic [7:0]  name_byte;
        logic        name_byte_valid;
        logic        last_of_entry;
    } out_item_t;

endpackage

FILE: design/dep_if.sv
interface dep_in_if;
    logic             valid;
    logic             ready;
    dep_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dep_out_if;
    logic              valid;
    logic              ready;
    dep_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: design/dep_parser.sv
module dep_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  dep_pkg::in_item_t  item,
    output logic               res_valid,
    output dep_pkg::out_item_t res
);

    logic [15:0] offset_reg;
    logic [15:0] offset_next;
    logic [31:0] inode_reg;
    logic [31:0] inode_next;
    logic [15:0] rec_len_reg;
    logic [15:0] rec_len_next;
    logic [7:0]  name_len_reg;
    logic [7:0]  name_len_next;
    logic [7:0]  kind_reg;
    logic [7:0]  kind_next;
    logic        halted_reg;
    logic        halted_next;

    logic [15:0] pos;
    logic [31:0] inode_cur;
    logic [15:0] rec_len_cur;
    logic [7:0]  name_len_cur;
    logic [7:0]  kind_cur;
    logic        halted_cur;
    logic [16:0] pos_ext;
    logic [16:0] pos_inc;
    logic [16:0] name_end;
    logic        stop;
    logic        incomplete;
    logic [7:0]  b;

    always_comb
    begin
        b            = item.data_byte;
        pos          = item.dir_start ? 16'd0 : offset_reg;
        inode_cur    = item.dir_start ? 32'd0 : inode_reg;
        rec_len_cur  = item.dir_start ? 16'd0 : rec_len_reg;
        name_len_cur = item.dir_start ? 8'd0 : name_len_reg;
        kind_cur     = item.dir_start ? 8'd0 : kind_reg;
        halted_cur   = item.dir_start ? 1'b0 : halted_reg;

        inode_next    = inode_cur;
        rec_len_next  = rec_len_cur;
        name_len_next = name_len_cur;
        kind_next     = kind_cur;
        halted_next   = halted_cur;
        offset_next   = pos;
        stop          = 1'b0;

        res_valid           = 1'b0;
        res.status          = dep_pkg::ST_DATA;
        res.name_byte       = 8'd0;
        res.name_byte_valid = 1'b0;
        res.last_of_entry   = 1'b1;

        pos_ext = {1'b0, pos};
        pos_inc = pos_ext + 17'd1;

        if (pos < dep_pkg::POS_RL_LO)
        begin
            if (pos == 16'd0)
            begin
                rec_len_next  = 16'd0;
                name_len_next = 8'd0;
                kind_next     = 8'd0;
                inode_next    = {24'd0, b};
            end
            else
            begin
                case (pos[1:0])
                    2'd1:    inode_next[15:8]  = b;
                    2'd2:    inode_next[23:16] = b;
                    2'd3:    inode_next[31:24] = b;
                    default: inode_next[7:0]   = b;
                endcase
            end
            if (pos[1:0] == 2'd3 && inode_next == 32'd0)
            begin
                res_valid  = 1'b1;
                res.status = dep_pkg::ST_END;
                stop       = 1'b1;
            end
        end
        else if (pos == dep_pkg::POS_RL_LO)
        begin
            rec_len_next = {8'd0, b};
        end
        else if (pos == dep_pkg::POS_RL_HI)
        begin
            rec_len_next[15:8] = b;
        end
        else if (pos == dep_pkg::POS_NAMELEN)
        begin
            name_len_next = b;
        end
        else if (pos == dep_pkg::POS_KIND)
        begin
            kind_next = b;
            if (rec_len_cur < dep_pkg::HDR_BYTES
                || {8'd0, name_len_cur} > rec_len_cur - dep_pkg::HDR_BYTES)
            begin
                res_valid  = 1'b1;
                res.status = dep_pkg::ST_BAD;
                stop       = 1'b1;
            end
            else if (name_len_cur == 8'd0)
            begin
                res_valid = 1'b1;
            end
        end

        name_end = {1'b0, dep_pkg::HDR_BYTES} + {9'd0, name_len_next};

        if (pos > dep_pkg::POS_KIND && pos_ext < name_end)
        begin
            res_valid           = 1'b1;
            res.name_byte       = b;
            res.name_byte_valid = 1'b1;
            res.last_of_entry   = (pos_inc == name_end);
        end

        if (!stop)
        begin
            if (pos >= dep_pkg::POS_KIND && pos_inc >= {1'b0, rec_len_next})
            begin
                offset_next = 16'd0;
            end
            else
            begin
                offset_next = pos_inc[15:0];
            end
            if (item.dir_end)
            begin
                incomplete = (pos < dep_pkg::POS_KIND) || (pos_inc < name_end);
                if (incomplete)
                begin
                    res_valid           = 1'b1;
                    res.status          = dep_pkg::ST_BAD;
                    res.name_byte       = 8'd0;
                    res.name_byte_valid = 1'b0;
                    res.last_of_entry   = 1'b1;
                end
                halted_next = 1'b1;
                offset_next = 16'd0;
            end
            else
            begin
                incomplete = 1'b0;
            end
        end
        else
        begin
            incomplete  = 1'b0;
            halted_next = 1'b1;
            offset_next = 16'd0;
        end

        if (halted_cur)
        begin
            res_valid     = 1'b0;
            inode_next    = inode_cur;
            rec_len_next  = rec_len_cur;
            name_len_next = name_len_cur;
            kind_next     = kind_cur;
            halted_next   = 1'b1;
            offset_next   = pos;
        end

        res.entry_inode   = inode_next;
        res.record_length = rec_len_next;
        res.name_length   = name_len_next;
        res.file_kind     = kind_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= 16'd0;
            inode_reg    <= 32'd0;
            rec_len_reg  <= 16'd0;
            name_len_reg <= 8'd0;
            kind_reg     <= 8'd0;
            halted_reg   <= 1'b0;
        end
        else if (fire)
        begin
            offset_reg   <= offset_next;
            inode_reg    <= inode_next;
            rec_len_reg  <= rec_len_next;
            name_len_reg <= name_len_next;
            kind_reg     <= kind_next;
            halted_reg   <= halted_next;
        end
    end

endmodule

FILE: design/dep_out_stage.sv
module dep_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  dep_pkg::out_item_t res,
    output logic               can_take,
    dep_out_if.source          out_ch
);

    logic               valid_reg;
    logic               valid_next;
    dep_pkg::out_item_t data_reg;

    assign can_take = !valid_reg || out_ch.ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign out_ch.valid = valid_reg;
    assign out_ch.data  = data_reg;

endmodule

FILE: design/dir_entry_stream_parser.sv
// Each byte is registered at the input, and its result is registered at the output.
// Throughput: one input byte per cycle, with at most one result per byte; a held
// result stalls the input.
// The loop through the entry offset and header registers sets the rate.
// Reset clears the entry offset, header fields and halt flag, and empties both
// the input register and the output register.
module dir_entry_stream_parser (
    input  logic      clk,
    input  logic      rst_n,
    dep_in_if.sink    in_ch,
    dep_out_if.source out_ch
);

    logic               in_valid_reg;
    logic               in_valid_next;
    dep_pkg::in_item_t  in_data_reg;
    logic               can_take;
    logic               fire;
    logic               res_valid;
    dep_pkg::out_item_t res;

    assign fire        = in_valid_reg && can_take;
    assign in_ch.ready = !in_valid_reg || can_take;

    always_comb
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_data_reg <= in_ch.data;
        end
    end

    dep_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (in_data_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    dep_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire && res_valid),
        .res      (res),
        .can_take (can_take),
        .out_ch   (out_ch)
    );

endmodule
